// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on a synchronous active-low reset domain
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HXC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define HXC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HXC_ASSERT(lbl, clk, rst_n, prop)
`define HXC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/hxc_pkg.sv -----
// ----------------------------------------------------------------------------
// hxc_pkg
// shared types, codes and character helpers of the hex text codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hxc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] REG_DECODE_MODE = 2'd0;
    localparam logic [1:0] REG_FORMAT_OUT  = 2'd1;
    localparam logic [1:0] REG_STRICT      = 2'd2;

    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ODD     = 2'd2;

    localparam logic [1:0] OP_ENC = 2'd0;
    localparam logic [1:0] OP_EOL = 2'd1;
    localparam logic [1:0] OP_DEC = 2'd2;
    localparam logic [1:0] OP_ERR = 2'd3;

    localparam logic [1:0] SEP_NONE = 2'd0;
    localparam logic [1:0] SEP_NL   = 2'd1;
    localparam logic [1:0] SEP_TWO  = 2'd2;
    localparam logic [1:0] SEP_ONE  = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] sep;
        logic [7:0] data;
        logic [1:0] status;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'd0, nib};
        if (nib < 4'd10) begin
            hex_char = 8'h30 + v;
        end else begin
            hex_char = 8'h57 + v;
        end
    endfunction

    // msb flags a hex digit, low nibble is its value
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            digit_value = {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            digit_value = {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            digit_value = {1'b1, d[3:0]};
        end else begin
            digit_value = 5'd0;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
    endfunction

endpackage

// ----- sv/hxc_front.sv -----
// ----------------------------------------------------------------------------
// hxc_front
// accepts items, keeps stream state and queues one job per item with output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hxc_front
    import hxc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    output logic       o_in_stall,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic       r_decode_mode;
    logic       r_format_out;
    logic       r_strict;
    logic [2:0] r_byte_pos;
    logic       r_seen;
    logic       r_pending;
    logic [3:0] r_nibble;
    logic       r_halted;

    logic [2:0] n_byte_pos;
    logic       n_seen;
    logic       n_pending;
    logic [3:0] n_nibble;
    logic       n_halted;

    logic       accept;
    logic [4:0] dig;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign dig        = digit_value(i_in_char);

    always_comb begin
        n_byte_pos = r_byte_pos;
        n_seen     = r_seen;
        n_pending  = r_pending;
        n_nibble   = r_nibble;
        n_halted   = r_halted;
        o_push     = 1'b0;
        o_job      = '{op: OP_ENC, sep: SEP_NONE, data: i_in_char, status: ST_DATA};
        if (!r_decode_mode) begin
            if (i_end_of_input) begin
                o_push    = r_format_out;
                o_job.op  = OP_EOL;
                n_byte_pos = 3'd0;
                n_seen     = 1'b0;
                n_pending  = 1'b0;
                n_nibble   = 4'd0;
                n_halted   = 1'b0;
            end else begin
                o_push = 1'b1;
                if (r_format_out && r_seen) begin
                    priority if (r_byte_pos == 3'd0) begin
                        o_job.sep = SEP_NL;
                    end else if (r_byte_pos[1:0] == 2'd0) begin
                        o_job.sep = SEP_TWO;
                    end else begin
                        o_job.sep = SEP_ONE;
                    end
                end
                n_byte_pos = r_byte_pos + 3'd1;
                n_seen     = 1'b1;
            end
        end else begin
            if (i_end_of_input) begin
                o_push       = !r_halted && r_pending;
                o_job.op     = OP_ERR;
                o_job.data   = 8'd0;
                o_job.status = ST_ODD;
                n_byte_pos = 3'd0;
                n_seen     = 1'b0;
                n_pending  = 1'b0;
                n_nibble   = 4'd0;
                n_halted   = 1'b0;
            end else if (!r_halted) begin
                if (dig[4]) begin
                    if (r_pending) begin
                        o_push     = 1'b1;
                        o_job.op   = OP_DEC;
                        o_job.data = {r_nibble, dig[3:0]};
                        n_pending  = 1'b0;
                        n_nibble   = 4'd0;
                    end else begin
                        n_pending = 1'b1;
                        n_nibble  = dig[3:0];
                    end
                end else if (r_strict && !is_space(i_in_char)) begin
                    o_push       = 1'b1;
                    o_job.op     = OP_ERR;
                    o_job.data   = 8'd0;
                    o_job.status = ST_INVALID;
                    n_pending    = 1'b0;
                    n_nibble     = 4'd0;
                    n_halted     = 1'b1;
                end
            end
        end
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_format_out  <= 1'b0;
            r_strict      <= 1'b0;
            r_byte_pos    <= 3'd0;
            r_seen        <= 1'b0;
            r_pending     <= 1'b0;
            r_nibble      <= 4'd0;
            r_halted      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DECODE_MODE: r_decode_mode <= i_cfg_data;
                    REG_FORMAT_OUT:  r_format_out  <= i_cfg_data;
                    REG_STRICT:      r_strict      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_byte_pos <= n_byte_pos;
                r_seen     <= n_seen;
                r_pending  <= n_pending;
                r_nibble   <= n_nibble;
                r_halted   <= n_halted;
            end
        end
    end

endmodule

// ----- sv/hxc_queue.sv -----
// ----------------------------------------------------------------------------
// hxc_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hxc_queue
    import hxc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);

    t_job          mem [DEPTH];
    logic [AW:0]   r_wr;
    logic [AW:0]   r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_head  = mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            mem[r_wr[AW-1:0]] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// ----- sv/hxc_back.sv -----
// ----------------------------------------------------------------------------
// hxc_back
// expands queued jobs into characters, one transfer per cycle while a job is queued and the output is not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hxc_back
    import hxc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_char;
    logic [1:0] r_status;
    logic       r_last;
    logic [1:0] r_step;

    logic       load;
    logic [1:0] nsep;
    logic [7:0] n_char;
    logic [1:0] n_status;
    logic       n_last;

    assign load = !i_empty && (!r_valid || !i_out_stall);
    assign o_pop = load && n_last;

    always_comb begin
        unique case (i_head.sep)
            SEP_NONE: nsep = 2'd0;
            SEP_TWO:  nsep = 2'd2;
            default:  nsep = 2'd1;
        endcase
        n_char   = 8'd0;
        n_status = ST_DATA;
        n_last   = 1'b1;
        unique case (i_head.op)
            OP_ENC: begin
                priority if (r_step < nsep) begin
                    n_char = (i_head.sep == SEP_NL) ? CH_NL : CH_SPACE;
                    n_last = 1'b0;
                end else if (r_step == nsep) begin
                    n_char = hex_char(i_head.data[7:4]);
                    n_last = 1'b0;
                end else begin
                    n_char = hex_char(i_head.data[3:0]);
                end
            end
            OP_EOL: n_char = CH_NL;
            OP_DEC: n_char = i_head.data;
            default: n_status = i_head.status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char   <= n_char;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= n_last ? 2'd0 : r_step + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_char  = r_char;
    assign o_status    = r_status;
    assign o_last      = r_last;

    `HXC_ASSERT(a_step_job_held, i_clk, i_rst_n, (r_step != 2'd0) |-> !i_empty)
    `HXC_ASSERT(a_error_shape, i_clk, i_rst_n, (r_valid && r_status != ST_DATA) |-> (r_last && r_char == 8'd0))
    `HXC_ASSERT(a_status_range, i_clk, i_rst_n, r_valid |-> (r_status != 2'd3))
    `HXC_ASSERT_NEXT(a_pop_resets_step, i_clk, i_rst_n, o_pop, r_step == 2'd0)

endmodule

// ----- sv/hex_text_codec_top.sv -----
// a result transfer passes through the job queue and then the output register after its item is accepted
// throughput: one character per cycle at the output while it is not stalled, up to four characters per item
// formatted encode gives up to four characters per byte, sent through the single-character output register
// a four-job queue lets the input keep accepting while the output is stalled, until the queue is full
// reset: synchronous active low, clears config, stream state, queue pointers and output valid; no clearing pass
// ----------------------------------------------------------------------------
// hex_text_codec_top
// hex text encoder and decoder with decoupled front, queue and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_text_codec_top
    import hxc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic push;
    t_job push_job;
    logic full;
    logic pop;
    t_job head;
    logic empty;

    assign o_cfg_ready = 1'b1;

    hxc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .o_in_stall     (o_in_stall),
        .i_full         (full),
        .o_push         (push),
        .o_job          (push_job)
    );

    hxc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    hxc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ----- bench/hex_text_codec_checker.sv -----
// ----------------------------------------------------------------------------
// hex_text_codec_checker
// watches the config, input and result channels of the hex text codec,
// keeps its own copy of the codec registers and stream state, works out the
// characters each accepted input transfer must produce and compares every
// result transfer against the oldest outstanding prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_text_codec_checker
    import hxc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_char,
    input  logic [1:0] i_status,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count
);

    localparam int         MAX_REPORTS = 10;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_LA    = 8'h61;
    localparam logic [7:0] ASCII_LF    = 8'h66;
    localparam logic [7:0] ASCII_UA    = 8'h41;
    localparam logic [7:0] ASCII_UF    = 8'h46;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] status;
        logic       last;
    } t_codec_result;

    t_codec_result expected_chars[$];
    t_codec_result want;

    logic       decode_mode;
    logic       format_output;
    logic       strict_check;

    logic [2:0] byte_count;
    logic       any_encoded;
    logic       have_high;
    logic [3:0] high_nibble;
    logic       stream_halted;

    int mismatch_count = 0;
    int checked_count  = 0;

    assign o_fail_count   = mismatch_count;
    assign o_result_count = checked_count;

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return ASCII_0 + {4'd0, n};
        end
        return ASCII_LA + {4'd0, n} - 8'd10;
    endfunction

    // letters in either case carry value 9 plus their low nibble
    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = c[3:0];
        if (c >= ASCII_0 && c <= ASCII_9) begin
            return 1'b1;
        end
        if ((c >= ASCII_LA && c <= ASCII_LF) || (c >= ASCII_UA && c <= ASCII_UF)) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic whitespace(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    task automatic clear_stream();
        byte_count    = 3'd0;
        any_encoded   = 1'b0;
        have_high     = 1'b0;
        high_nibble   = 4'd0;
        stream_halted = 1'b0;
    endtask

    task automatic predict_codec_output(input logic [7:0] c, input logic eoi);
        logic [7:0]    res_char [4];
        logic [1:0]    res_status [4];
        logic [3:0]    v;
        t_codec_result r;
        int            n;
        n = 0;
        for (int k = 0; k < 4; k++) begin
            res_char[k]   = 8'd0;
            res_status[k] = ST_DATA;
        end
        if (!decode_mode) begin
            if (eoi) begin
                if (format_output) begin
                    res_char[n] = CH_NL;
                    n++;
                end
                clear_stream();
            end else begin
                if (format_output && any_encoded) begin
                    if (byte_count == 3'd0) begin
                        res_char[n] = CH_NL;
                        n++;
                    end else if (byte_count[1:0] == 2'd0) begin
                        res_char[n]     = CH_SPACE;
                        res_char[n + 1] = CH_SPACE;
                        n += 2;
                    end else begin
                        res_char[n] = CH_SPACE;
                        n++;
                    end
                end
                res_char[n]     = nibble_char(c[7:4]);
                res_char[n + 1] = nibble_char(c[3:0]);
                n += 2;
                byte_count  = byte_count + 3'd1;
                any_encoded = 1'b1;
            end
        end else begin
            if (eoi) begin
                if (!stream_halted && have_high) begin
                    res_status[n] = ST_ODD;
                    n++;
                end
                clear_stream();
            end else if (!stream_halted) begin
                if (hex_digit(c, v)) begin
                    if (have_high) begin
                        res_char[n] = {high_nibble, v};
                        n++;
                        have_high   = 1'b0;
                        high_nibble = 4'd0;
                    end else begin
                        high_nibble = v;
                        have_high   = 1'b1;
                    end
                end else if (strict_check && !whitespace(c)) begin
                    res_status[n] = ST_INVALID;
                    n++;
                    have_high     = 1'b0;
                    high_nibble   = 4'd0;
                    stream_halted = 1'b1;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            r.ch     = res_char[k];
            r.status = res_status[k];
            r.last   = (k == n - 1);
            expected_chars.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            decode_mode   = 1'b0;
            format_output = 1'b0;
            strict_check  = 1'b0;
            clear_stream();
            expected_chars.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_codec_output(i_in_char, i_end_of_input);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DECODE_MODE: decode_mode   = i_cfg_data;
                    REG_FORMAT_OUT:  format_output = i_cfg_data;
                    REG_STRICT:      strict_check  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                checked_count++;
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result char %02h status %0d last %0d",
                                 $time, i_out_char, i_status, i_last);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== i_out_char || want.status !== i_status
                            || want.last !== i_last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: result mismatch: expected char %02h status %0d",
                                     $time, want.ch, want.status,
                                     " last %0d, got char %02h status %0d last %0d",
                                     want.last, i_out_char, i_status, i_last);
                        end
                    end
                end
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

// ----- bench/hex_text_codec_top_test.sv -----
// ----------------------------------------------------------------------------
// hex_text_codec_top_test
// drives the hex text codec through directed encode and decode streams and
// then randomized phases over every register setting, with random idle and
// stall cycles on both data channels; the checker does all prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_text_codec_top_test;
    import hxc_pkg::*;

    localparam int IDLE_RANDOM   = 0;
    localparam int IDLE_NONE     = 1;
    localparam int IDLE_SPARSE   = 2;
    localparam int MAX_WAIT      = 18;
    localparam int HOLDOFF       = 10;
    localparam int WATCHDOG      = 2000;
    localparam int PHASES        = 13;
    localparam int PHASE_ITEMS   = 34;

    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_UA = 8'h41;

    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [1:0] i_cfg_index    = REG_DECODE_MODE;
    logic       i_cfg_data     = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_in_char      = 8'd0;
    logic       i_end_of_input = 1'b0;
    logic       i_out_stall    = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic [1:0] o_status;
    logic       o_last;

    int fail_count;
    int pending_count;
    int result_count;
    int item_count = 0;
    int reg_writes = 0;
    int in_mode    = IDLE_RANDOM;
    int out_mode   = IDLE_RANDOM;
    int idle_cycles = 0;

    hex_text_codec_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_char     (o_out_char),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    hex_text_codec_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_char     (o_out_char),
        .i_status       (o_status),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input int mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
            default:     return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic logic [7:0] hex_text_char(input int noise_pct);
        int         r;
        logic [3:0] v;
        r = $urandom_range(0, 99);
        v = 4'($urandom_range(0, 15));
        if (r < noise_pct) begin
            return 8'($urandom_range(0, 255));
        end
        if (r < noise_pct + 15) begin
            case ($urandom_range(0, 3))
                0:       return CH_SPACE;
                1:       return CH_TAB;
                2:       return CH_NL;
                default: return CH_CR;
            endcase
        end
        if (v < 4'd10) begin
            return ASCII_0 + {4'd0, v};
        end
        return ($urandom_range(0, 1) ? ASCII_UA : ASCII_LA) + {4'd0, v} - 8'd10;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = draw_wait(in_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_char      <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_in_stall);
        item_count++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (HOLDOFF) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    initial begin : result_sink
        int hold;
        forever begin
            hold = draw_wait(out_mode);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic dec;
        logic fmt;
        logic strict;
        int   errors;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain encode, end gives nothing
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h5a, 1'b1);

        // formatted encode across single, double and newline separators
        write_reg(REG_FORMAT_OUT, 1'b1);
        for (int k = 0; k < 9; k++) begin
            send_char(8'(k * 37 + 3), 1'b0);
        end
        send_char(8'hc3, 1'b1);

        // lenient decode with whitespace, junk and an odd end
        write_reg(REG_DECODE_MODE, 1'b1);
        send_char("0", 1'b0);
        send_char("F", 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char("a", 1'b0);
        send_char("G", 1'b0);
        send_char("9", 1'b0);
        send_char(CH_CR, 1'b0);
        send_char("B", 1'b0);
        send_char(CH_NL, 1'b0);
        send_char("7", 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char("C", 1'b0);
        send_char(8'h00, 1'b1);

        // strict decode halts on junk until end of input
        write_reg(REG_STRICT, 1'b1);
        send_char("1", 1'b0);
        send_char(8'hff, 1'b0);
        send_char("2", 1'b0);
        send_char(8'hff, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                dec    = p[0];
                fmt    = p[1];
                strict = p[2];
            end else begin
                dec    = 1'($urandom_range(0, 1));
                fmt    = 1'($urandom_range(0, 1));
                strict = 1'($urandom_range(0, 1));
            end
            write_reg(REG_DECODE_MODE, dec);
            write_reg(REG_FORMAT_OUT, fmt);
            write_reg(REG_STRICT, strict);
            in_mode  = (p % 4 == 3) ? IDLE_NONE : $urandom_range(0, 2);
            out_mode = (p % 4 == 1) ? IDLE_NONE : $urandom_range(0, 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 13) == 0) begin
                    send_char(8'($urandom_range(0, 255)), 1'b1);
                end else if (dec) begin
                    send_char(hex_text_char(strict ? 3 : 12), 1'b0);
                end else begin
                    send_char(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (HOLDOFF) @(posedge i_clk);
        errors = fail_count + pending_count;
        $display("%0d input transfers, %0d result transfers checked, %0d register writes",
                 item_count, result_count, reg_writes);
        $display("covered encode and decode under all register settings with random idling");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
